@@ hdl/tpsp_pkg.sv @@
package tpsp_pkg;

  // Coordinate width of vertices, crossings and the slice height.
  localparam int CoordWidth = 32;
  localparam int TolWidth   = 16;
  localparam int IdxWidth   = 20;

  // Differences and their magnitudes need one extra bit.
  localparam int MagW     = CoordWidth + 1;
  // The multiplier takes the second operand in two halves.
  localparam int HalfW    = (MagW + 1) / 2;
  localparam int PartW    = MagW + HalfW;
  localparam int ProdW    = 2 * MagW;
  localparam int DivCntW  = $clog2(MagW);

  localparam logic [TolWidth-1:0] TolReset = TolWidth'(66);

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [MagW-1:0]       diff_t;
  typedef logic [MagW-1:0]              mag_t;
  typedef logic [HalfW-1:0]             half_t;
  typedef logic [PartW-1:0]             part_t;
  typedef logic [ProdW-1:0]             prod_t;
  typedef logic [DivCntW-1:0]           div_cnt_t;
  typedef logic [TolWidth-1:0]          tol_t;
  typedef logic [IdxWidth-1:0]          idx_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_SLICE_HEIGHT = 1'b0,
    CFG_MERGE_TOL    = 1'b1
  } cfg_idx_t;

  // Request to the shared multiply-divide unit: q = a * b / d.
  typedef struct packed {
    logic start;
    mag_t a;
    mag_t b;
    mag_t d;
  } md_req_t;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL_LO,
    MD_MUL_HI,
    MD_ACC,
    MD_DIV,
    MD_DONE
  } md_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EDGE,
    ST_X_GO,
    ST_X_RUN,
    ST_Y_GO,
    ST_Y_RUN,
    ST_MERGE_D,
    ST_MERGE_C,
    ST_NEXT,
    ST_PUT
  } seq_state_t;

  // Magnitude of a signed difference.
  function automatic mag_t mag_of(input diff_t v);
    mag_t r;
    if (v[MagW-1]) begin
      r = mag_t'(-v);
    end else begin
      r = mag_t'(v);
    end
    return r;
  endfunction

endpackage

@@ hdl/tpsp_muldiv.sv @@
module tpsp_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  tpsp_pkg::md_req_t req,
  output logic              done,
  output tpsp_pkg::mag_t    q
);

  tpsp_pkg::md_state_t state;
  tpsp_pkg::md_state_t state_next;
  tpsp_pkg::mag_t      a_r;
  tpsp_pkg::mag_t      b_r;
  tpsp_pkg::mag_t      d_r;
  tpsp_pkg::part_t     part;
  tpsp_pkg::part_t     prod_lo;
  tpsp_pkg::mag_t      rem;
  tpsp_pkg::mag_t      qsh;
  tpsp_pkg::div_cnt_t  cnt;

  tpsp_pkg::half_t     mul_sel;
  tpsp_pkg::part_t     mul_res;
  tpsp_pkg::prod_t     sum;
  logic [tpsp_pkg::MagW:0] trial;
  logic [tpsp_pkg::MagW:0] trial_sub;
  logic                ge;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tpsp_pkg::MD_IDLE: begin
        if (req.start) begin
          state_next = tpsp_pkg::MD_MUL_LO;
        end
      end
      tpsp_pkg::MD_MUL_LO: state_next = tpsp_pkg::MD_MUL_HI;
      tpsp_pkg::MD_MUL_HI: state_next = tpsp_pkg::MD_ACC;
      tpsp_pkg::MD_ACC:    state_next = tpsp_pkg::MD_DIV;
      tpsp_pkg::MD_DIV: begin
        if (cnt == tpsp_pkg::div_cnt_t'(tpsp_pkg::MagW - 1)) begin
          state_next = tpsp_pkg::MD_DONE;
        end
      end
      tpsp_pkg::MD_DONE:   state_next = tpsp_pkg::MD_IDLE;
      default:             state_next = tpsp_pkg::MD_IDLE;
    endcase
  end

  // Outputs and operand selection.
  always_comb begin
    done    = (state == tpsp_pkg::MD_DONE);
    q       = qsh;
    mul_sel = tpsp_pkg::half_t'(b_r);
    if (state == tpsp_pkg::MD_MUL_HI) begin
      mul_sel = tpsp_pkg::half_t'(b_r >> tpsp_pkg::HalfW);
    end
  end

  // One partial product per cycle, then one quotient bit per cycle.
  assign mul_res   = tpsp_pkg::part_t'(a_r) * tpsp_pkg::part_t'(mul_sel);
  assign sum       = tpsp_pkg::prod_t'(prod_lo)
                   + (tpsp_pkg::prod_t'(part) << tpsp_pkg::HalfW);
  assign trial     = {rem, qsh[tpsp_pkg::MagW-1]};
  assign trial_sub = trial - {1'b0, d_r};
  assign ge        = (trial >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpsp_pkg::MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      tpsp_pkg::MD_IDLE: begin
        if (req.start) begin
          a_r <= req.a;
          b_r <= req.b;
          d_r <= req.d;
        end
      end
      tpsp_pkg::MD_MUL_LO: begin
        part <= mul_res;
      end
      tpsp_pkg::MD_MUL_HI: begin
        prod_lo <= part;
        part    <= mul_res;
      end
      tpsp_pkg::MD_ACC: begin
        // The upper half of the product is already below the divisor.
        rem <= tpsp_pkg::mag_t'(sum >> tpsp_pkg::MagW);
        qsh <= tpsp_pkg::mag_t'(sum);
        cnt <= '0;
      end
      tpsp_pkg::MD_DIV: begin
        rem <= ge ? tpsp_pkg::mag_t'(trial_sub) : tpsp_pkg::mag_t'(trial);
        qsh <= {qsh[tpsp_pkg::MagW-2:0], ge};
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // A new request only arrives while the unit is free.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == tpsp_pkg::MD_IDLE)
    else $error("multiply-divide started while busy");

  // The caller keeps b below d, so the quotient never exceeds a.
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> q <= a_r)
    else $error("quotient exceeds first factor");

  // The remainder stays below the divisor throughout the division.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == tpsp_pkg::MD_DIV |-> rem < d_r)
    else $error("division remainder out of range");

endmodule

@@ hdl/triangle_plane_slice_points_core.sv @@
// Channel   Handshake                Payload
// input     in_valid / in_ready      ax ay az bx by bz cx cy cz tri_index layer_start
// output    out_valid / out_ready    point_x point_y point_z point_tri_index degenerate last
// config    cfg_write                cfg_index cfg_data
//
// Each crossing edge runs an X and a Y division on the one shared multiply-divide unit,
// which yields one quotient bit per cycle.
// in_ready is high only while the sequencer is idle; one triangle is in work at a time.
// Results sit in an output register, so a new triangle is taken while the last waits.
// Synchronous reset clears the sequencer, layer state and slice height; merge_tol gets TolReset.
module triangle_plane_slice_points_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  tpsp_pkg::coord_t          ax,
  input  tpsp_pkg::coord_t          ay,
  input  tpsp_pkg::coord_t          az,
  input  tpsp_pkg::coord_t          bx,
  input  tpsp_pkg::coord_t          by,
  input  tpsp_pkg::coord_t          bz,
  input  tpsp_pkg::coord_t          cx,
  input  tpsp_pkg::coord_t          cy,
  input  tpsp_pkg::coord_t          cz,
  input  tpsp_pkg::idx_t            tri_index,
  input  logic                      layer_start,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tpsp_pkg::coord_t          point_x,
  output tpsp_pkg::coord_t          point_y,
  output tpsp_pkg::coord_t          point_z,
  output tpsp_pkg::idx_t            point_tri_index,
  output logic                      degenerate,
  output logic                      last,
  input  logic                      cfg_write,
  input  tpsp_pkg::cfg_idx_t        cfg_index,
  input  tpsp_pkg::coord_t          cfg_data
);

  tpsp_pkg::seq_state_t state;
  tpsp_pkg::seq_state_t state_next;

  tpsp_pkg::coord_t slice_height;
  tpsp_pkg::tol_t   merge_tol;
  logic             layer_void;

  // Vertex registers rotate by one place after each edge.
  tpsp_pkg::coord_t vx [3];
  tpsp_pkg::coord_t vy [3];
  tpsp_pkg::coord_t vz [3];
  tpsp_pkg::idx_t   tri_idx;

  logic [1:0]       edge_cnt;
  logic [1:0]       npts;
  tpsp_pkg::diff_t  dpx;
  tpsp_pkg::diff_t  dpy;
  tpsp_pkg::diff_t  dz;
  tpsp_pkg::diff_t  dh;
  tpsp_pkg::coord_t cur_x;
  tpsp_pkg::coord_t cur_y;
  tpsp_pkg::diff_t  ddx;
  tpsp_pkg::diff_t  ddy;
  tpsp_pkg::coord_t p0x;
  tpsp_pkg::coord_t p0y;
  tpsp_pkg::coord_t p1x;
  tpsp_pkg::coord_t p1y;
  logic             emit_k;
  logic             emit_deg;

  tpsp_pkg::md_req_t md_req;
  logic              md_done;
  tpsp_pkg::mag_t    md_q;

  logic              on_plane;
  logic              crossing;
  logic              close;
  logic              last_now;
  logic              out_load;
  logic              neg_x;
  logic              neg_y;
  tpsp_pkg::diff_t   tol_s;
  tpsp_pkg::diff_t   q_s;
  tpsp_pkg::coord_t  prev_x;
  tpsp_pkg::coord_t  prev_y;

  tpsp_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .req  (md_req),
    .done (md_done),
    .q    (md_q)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_height <= '0;
      merge_tol    <= tpsp_pkg::TolReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tpsp_pkg::CFG_SLICE_HEIGHT: slice_height <= cfg_data;
        tpsp_pkg::CFG_MERGE_TOL:    merge_tol    <= tpsp_pkg::tol_t'(cfg_data);
      endcase
    end
  end

  // Decisions on the current triangle and edge.
  assign on_plane = (vz[0] == slice_height) || (vz[1] == slice_height)
                 || (vz[2] == slice_height);
  assign crossing = (vz[0] > slice_height) != (vz[1] > slice_height);
  assign neg_x    = dpx[tpsp_pkg::MagW-1] ^ dh[tpsp_pkg::MagW-1] ^ dz[tpsp_pkg::MagW-1];
  assign neg_y    = dpy[tpsp_pkg::MagW-1] ^ dh[tpsp_pkg::MagW-1] ^ dz[tpsp_pkg::MagW-1];
  assign q_s      = tpsp_pkg::diff_t'(md_q);
  assign tol_s    = tpsp_pkg::diff_t'(merge_tol);
  assign close    = (npts != 2'd0)
                 && (ddx < tol_s) && (ddx > -tol_s)
                 && (ddy < tol_s) && (ddy > -tol_s);
  assign prev_x   = (npts == 2'd2) ? p1x : p0x;
  assign prev_y   = (npts == 2'd2) ? p1y : p0y;
  assign last_now = emit_deg || ((2'(emit_k) + 2'd1) == npts);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tpsp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = tpsp_pkg::ST_CHECK;
        end
      end
      tpsp_pkg::ST_CHECK: begin
        if (layer_void) begin
          state_next = tpsp_pkg::ST_IDLE;
        end else if (on_plane) begin
          state_next = tpsp_pkg::ST_PUT;
        end else begin
          state_next = tpsp_pkg::ST_EDGE;
        end
      end
      tpsp_pkg::ST_EDGE: begin
        state_next = crossing ? tpsp_pkg::ST_X_GO : tpsp_pkg::ST_NEXT;
      end
      tpsp_pkg::ST_X_GO: state_next = tpsp_pkg::ST_X_RUN;
      tpsp_pkg::ST_X_RUN: begin
        if (md_done) begin
          state_next = tpsp_pkg::ST_Y_GO;
        end
      end
      tpsp_pkg::ST_Y_GO: state_next = tpsp_pkg::ST_Y_RUN;
      tpsp_pkg::ST_Y_RUN: begin
        if (md_done) begin
          state_next = tpsp_pkg::ST_MERGE_D;
        end
      end
      tpsp_pkg::ST_MERGE_D: state_next = tpsp_pkg::ST_MERGE_C;
      tpsp_pkg::ST_MERGE_C: state_next = tpsp_pkg::ST_NEXT;
      tpsp_pkg::ST_NEXT: begin
        if (edge_cnt == 2'd2) begin
          state_next = (npts == 2'd0) ? tpsp_pkg::ST_IDLE : tpsp_pkg::ST_PUT;
        end else begin
          state_next = tpsp_pkg::ST_EDGE;
        end
      end
      tpsp_pkg::ST_PUT: begin
        if (out_load && last_now) begin
          state_next = tpsp_pkg::ST_IDLE;
        end
      end
      default: state_next = tpsp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready     = (state == tpsp_pkg::ST_IDLE);
    out_load     = (state == tpsp_pkg::ST_PUT) && (!out_valid || out_ready);
    md_req.start = (state == tpsp_pkg::ST_X_GO) || (state == tpsp_pkg::ST_Y_GO);
    md_req.a     = (state == tpsp_pkg::ST_Y_GO) ? tpsp_pkg::mag_of(dpy)
                                                : tpsp_pkg::mag_of(dpx);
    md_req.b     = tpsp_pkg::mag_of(dh);
    md_req.d     = tpsp_pkg::mag_of(dz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpsp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Layer state: cleared by a layer start, set by a vertex on the plane.
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_void <= 1'b0;
    end else if (state == tpsp_pkg::ST_IDLE && in_valid && layer_start) begin
      layer_void <= 1'b0;
    end else if (state == tpsp_pkg::ST_CHECK && !layer_void && on_plane) begin
      layer_void <= 1'b1;
    end
  end

  // Triangle datapath.
  always_ff @(posedge clk) begin
    case (state)
      tpsp_pkg::ST_IDLE: begin
        if (in_valid) begin
          vx[0]    <= ax;
          vy[0]    <= ay;
          vz[0]    <= az;
          vx[1]    <= bx;
          vy[1]    <= by;
          vz[1]    <= bz;
          vx[2]    <= cx;
          vy[2]    <= cy;
          vz[2]    <= cz;
          tri_idx  <= tri_index;
          edge_cnt <= 2'd0;
          npts     <= 2'd0;
        end
      end
      tpsp_pkg::ST_CHECK: begin
        emit_deg <= on_plane;
        emit_k   <= 1'b0;
      end
      tpsp_pkg::ST_EDGE: begin
        dz  <= tpsp_pkg::diff_t'(vz[1]) - tpsp_pkg::diff_t'(vz[0]);
        dh  <= tpsp_pkg::diff_t'(slice_height) - tpsp_pkg::diff_t'(vz[0]);
        dpx <= tpsp_pkg::diff_t'(vx[1]) - tpsp_pkg::diff_t'(vx[0]);
        dpy <= tpsp_pkg::diff_t'(vy[1]) - tpsp_pkg::diff_t'(vy[0]);
      end
      tpsp_pkg::ST_X_RUN: begin
        if (md_done) begin
          cur_x <= neg_x ? tpsp_pkg::coord_t'(tpsp_pkg::diff_t'(vx[0]) - q_s)
                         : tpsp_pkg::coord_t'(tpsp_pkg::diff_t'(vx[0]) + q_s);
        end
      end
      tpsp_pkg::ST_Y_RUN: begin
        if (md_done) begin
          cur_y <= neg_y ? tpsp_pkg::coord_t'(tpsp_pkg::diff_t'(vy[0]) - q_s)
                         : tpsp_pkg::coord_t'(tpsp_pkg::diff_t'(vy[0]) + q_s);
        end
      end
      tpsp_pkg::ST_MERGE_D: begin
        ddx <= tpsp_pkg::diff_t'(prev_x) - tpsp_pkg::diff_t'(cur_x);
        ddy <= tpsp_pkg::diff_t'(prev_y) - tpsp_pkg::diff_t'(cur_y);
      end
      tpsp_pkg::ST_MERGE_C: begin
        // Two crossings too close together cancel each other.
        if (close) begin
          npts <= npts - 2'd1;
        end else if (npts == 2'd0) begin
          p0x  <= cur_x;
          p0y  <= cur_y;
          npts <= 2'd1;
        end else if (npts == 2'd1) begin
          p1x  <= cur_x;
          p1y  <= cur_y;
          npts <= 2'd2;
        end
      end
      tpsp_pkg::ST_NEXT: begin
        vx[0]    <= vx[1];
        vx[1]    <= vx[2];
        vx[2]    <= vx[0];
        vy[0]    <= vy[1];
        vy[1]    <= vy[2];
        vy[2]    <= vy[0];
        vz[0]    <= vz[1];
        vz[1]    <= vz[2];
        vz[2]    <= vz[0];
        edge_cnt <= edge_cnt + 2'd1;
      end
      tpsp_pkg::ST_PUT: begin
        if (out_load) begin
          emit_k <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      point_x         <= emit_deg ? '0 : (emit_k ? p1x : p0x);
      point_y         <= emit_deg ? '0 : (emit_k ? p1y : p0y);
      point_z         <= emit_deg ? '0 : slice_height;
      point_tri_index <= tri_idx;
      degenerate      <= emit_deg;
      last            <= last_now;
    end
  end

  // A degenerate result is alone and carries a zero point.
  a_deg_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> last && point_x == '0 && point_z == '0)
    else $error("degenerate result malformed");

  // Emitting a degenerate result means the layer has been voided.
  a_deg_void: assert property (@(posedge clk) disable iff (rst)
    out_load && emit_deg |=> layer_void)
    else $error("degenerate result without void layer");

  // Results are only sent when there is something to send.
  a_put_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == tpsp_pkg::ST_PUT |-> emit_deg || npts != 2'd0)
    else $error("result stage entered with no points");

  // A triangle transaction always starts with the layer check.
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == tpsp_pkg::ST_CHECK)
    else $error("accepted triangle not checked");

endmodule

@@ dv/slice_point_checker.sv @@
`timescale 1ns / 100ps

// Watches the configuration port and both channels of the slicer, works out the crossing
// points of every accepted triangle and compares them with what comes out.
module slice_point_checker
  import tpsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  coord_t   ax,
  input  coord_t   ay,
  input  coord_t   az,
  input  coord_t   bx,
  input  coord_t   by,
  input  coord_t   bz,
  input  coord_t   cx,
  input  coord_t   cy,
  input  coord_t   cz,
  input  idx_t     tri_index,
  input  logic     layer_start,
  input  logic     out_valid,
  input  logic     out_ready,
  input  coord_t   point_x,
  input  coord_t   point_y,
  input  coord_t   point_z,
  input  idx_t     point_tri_index,
  input  logic     degenerate,
  input  logic     last,
  input  logic     cfg_write,
  input  cfg_idx_t cfg_index,
  input  coord_t   cfg_data,
  output int       fail_count,
  output int       pending
);

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    idx_t   idx;
    logic   degen;
    logic   last;
  } point_t;

  // Expected crossing points, oldest first.
  point_t expected_points[$];
  point_t head;

  // Shadow copy of the configuration and the layer state.
  coord_t cut_height;
  tol_t   merge_tol;
  logic   layer_void;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Distance between two coordinates, one bit wider than a coordinate.
  function automatic logic [32:0] abs_diff(input coord_t a, input coord_t b);
    logic signed [33:0] d;
    d = a - b;
    return d[33] ? 33'(-d) : 33'(d);
  endfunction

  // Point where the plane cuts one edge: p1 + dp * (h - z1) / dz, truncated toward zero.
  function automatic coord_t edge_cross(input coord_t p1, input coord_t p2,
                                        input coord_t z1, input coord_t z2,
                                        input coord_t h);
    logic [65:0]        mp, mh, mz, prod, quo;
    logic signed [33:0] sum;
    logic               neg;
    mp   = abs_diff(p2, p1);
    mh   = abs_diff(h, z1);
    mz   = abs_diff(z2, z1);
    prod = mp * mh;
    quo  = prod / mz;
    neg  = (p2 < p1) ^ (h < z1) ^ (z2 < z1);
    sum  = p1;
    sum  = neg ? sum - $signed({1'b0, quo[32:0]}) : sum + $signed({1'b0, quo[32:0]});
    return sum[31:0];
  endfunction

  // Works out the results of one triangle and queues them.
  function automatic void predict_triangle(input coord_t x0, input coord_t y0,
                                           input coord_t z0, input coord_t x1,
                                           input coord_t y1, input coord_t z1,
                                           input coord_t x2, input coord_t y2,
                                           input coord_t z2, input idx_t idx,
                                           input logic new_layer);
    coord_t vx[3], vy[3], vz[3], px[3], py[3];
    coord_t hit_x, hit_y;
    int     n, f;
    vx[0] = x0; vy[0] = y0; vz[0] = z0;
    vx[1] = x1; vy[1] = y1; vz[1] = z1;
    vx[2] = x2; vy[2] = y2; vz[2] = z2;
    if (new_layer) begin
      layer_void = 1'b0;
    end
    if (layer_void) begin
      return;
    end
    // A vertex on the plane voids the rest of the layer and gives one flagged result.
    if (vz[0] == cut_height || vz[1] == cut_height || vz[2] == cut_height) begin
      layer_void = 1'b1;
      expected_points.push_back('{x: '0, y: '0, z: '0, idx: idx, degen: 1'b1, last: 1'b1});
      return;
    end
    n = 0;
    for (int e = 0; e < 3; e++) begin
      f = (e == 2) ? 0 : e + 1;
      if ((vz[e] < cut_height && vz[f] > cut_height) ||
          (vz[e] > cut_height && vz[f] < cut_height)) begin
        hit_x = edge_cross(vx[e], vx[f], vz[e], vz[f], cut_height);
        hit_y = edge_cross(vy[e], vy[f], vz[e], vz[f], cut_height);
        // Two crossings closer than the tolerance in X and Y cancel each other.
        if (n > 0 && abs_diff(px[n-1], hit_x) < merge_tol &&
            abs_diff(py[n-1], hit_y) < merge_tol) begin
          n--;
        end else begin
          px[n] = hit_x;
          py[n] = hit_y;
          n++;
        end
      end
    end
    if (n > 2) begin
      n = 2;
    end
    for (int k = 0; k < n; k++) begin
      expected_points.push_back('{x: px[k], y: py[k], z: cut_height, idx: idx,
                                  degen: 1'b0, last: (k == n - 1)});
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cut_height = '0;
      merge_tol  = TolReset;
      layer_void = 1'b0;
      expected_points.delete();
    end else begin
      // Compare an output transaction with the oldest expectation.
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result x=0x%h y=0x%h z=0x%h tri=0x%h deg=%b last=%b,",
                   $time, point_x, point_y, point_z, point_tri_index, degenerate, last,
                   " expected none");
          fail_count++;
        end else begin
          head = expected_points.pop_front();
          check_field("point_x", head.x, point_x);
          check_field("point_y", head.y, point_y);
          check_field("point_z", head.z, point_z);
          check_field("point_tri_index", 32'(head.idx), 32'(point_tri_index));
          check_field("degenerate", 32'(head.degen), 32'(degenerate));
          check_field("last", 32'(head.last), 32'(last));
        end
      end

      // Register writes.
      if (cfg_write) begin
        case (cfg_index)
          CFG_SLICE_HEIGHT: begin
            cut_height = cfg_data;
          end
          CFG_MERGE_TOL: begin
            merge_tol = cfg_data[TolWidth-1:0];
          end
          default: begin
          end
        endcase
      end

      // Input transaction.
      if (in_valid && in_ready) begin
        predict_triangle(ax, ay, az, bx, by, bz, cx, cy, cz, tri_index, layer_start);
      end
    end
    pending = expected_points.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import tpsp_pkg::*;

  localparam int     CYCLE_LIMIT   = 1000000;
  localparam int     SETTLE_CYCLES = 250;
  localparam int     HOLD_CYCLES   = 600;
  localparam coord_t Q_ONE         = 32'sh0001_0000;
  localparam coord_t COORD_MAX     = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN     = coord_t'(32'h8000_0000);
  localparam tol_t   TOL_MAX       = 16'hFFFF;

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  coord_t   ax, ay, az, bx, by, bz, cx, cy, cz;
  idx_t     tri_index;
  logic     layer_start;
  logic     out_valid;
  logic     out_ready;
  coord_t   point_x, point_y, point_z;
  idx_t     point_tri_index;
  logic     degenerate;
  logic     last;
  logic     cfg_write;
  cfg_idx_t cfg_index;
  coord_t   cfg_data;
  int       fail_count;
  int       pending;

  int       tx_idle_pct;
  int       rx_idle_pct;
  logic     hold_kick;
  coord_t   cur_height;
  int       cycle_count = 0;

  triangle_plane_slice_points_core dut (.*);

  slice_point_checker point_check (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request from the stimulus.
  initial begin
    int   hold_left;
    logic kick_seen;
    out_ready = 1'b0;
    hold_left = 0;
    kick_seen = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_kick != kick_seen) begin
        kick_seen = hold_kick;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  function automatic int rand_span(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 5))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      3: return -1;
      4: return 1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic set_idle(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input coord_t value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Offers one triangle and waits for its transaction.
  task automatic send_tri(input coord_t x0, input coord_t y0, input coord_t z0,
                          input coord_t x1, input coord_t y1, input coord_t z1,
                          input coord_t x2, input coord_t y2, input coord_t z2,
                          input idx_t idx, input logic new_layer);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    ax <= x0; ay <= y0; az <= z0;
    bx <= x1; by <= y1; bz <= z1;
    cx <= x2; cy <= y2; cz <= z2;
    tri_index   <= idx;
    layer_start <= new_layer;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random triangle: half near the plane, some with a tip just off the plane so
  // that the two crossings merge, some fully random and some built from extreme values.
  task automatic send_random();
    coord_t vx[3], vy[3], vz[3];
    coord_t base_x, base_y;
    int     mode, tip, side, off;
    mode   = $urandom_range(0, 99);
    tip    = $urandom_range(0, 2);
    side   = ($urandom_range(0, 1) == 1) ? 1 : -1;
    base_x = rand_span(1 << 24);
    base_y = rand_span(1 << 24);
    for (int v = 0; v < 3; v++) begin
      if (mode < 50) begin
        off   = rand_span(1 << 20);
        if (off == 0) begin
          off = 1;
        end
        vx[v] = rand_span(1 << 24);
        vy[v] = rand_span(1 << 24);
        vz[v] = cur_height + off;
      end else if (mode < 70) begin
        if (v == tip) begin
          vx[v] = base_x + rand_span(1 << 10);
          vy[v] = base_y + rand_span(1 << 10);
          vz[v] = cur_height + side * int'($urandom_range(1, 4));
        end else begin
          vx[v] = base_x + rand_span(1 << 20);
          vy[v] = base_y + rand_span(1 << 20);
          vz[v] = cur_height - side * int'($urandom_range(1 << 16, 1 << 20));
        end
      end else if (mode < 85) begin
        vx[v] = coord_t'($urandom);
        vy[v] = coord_t'($urandom);
        vz[v] = coord_t'($urandom);
      end else begin
        vx[v] = pick_extreme();
        vy[v] = pick_extreme();
        vz[v] = pick_extreme();
      end
    end
    // Now and then a vertex sits exactly on the plane.
    if ($urandom_range(0, 99) < 4) begin
      vz[$urandom_range(0, 2)] = cur_height;
    end
    send_tri(vx[0], vy[0], vz[0], vx[1], vy[1], vz[1], vx[2], vy[2], vz[2],
             idx_t'($urandom), ($urandom_range(0, 99) < 15));
  endtask

  task automatic send_many(input int count);
    repeat (count) send_random();
  endtask

  // Sender pause until every expected result has been taken.
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Block idle: results drained and any triangle without results finished.
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input coord_t h, input tol_t tol);
    cur_height = h;
    write_reg(CFG_SLICE_HEIGHT, h);
    write_reg(CFG_MERGE_TOL, coord_t'({16'b0, tol}));
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    {ax, ay, az, bx, by, bz, cx, cy, cz} = '0;
    tri_index   = '0;
    layer_start = 1'b0;
    cfg_write   = 1'b0;
    cfg_index   = CFG_SLICE_HEIGHT;
    cfg_data    = '0;
    hold_kick   = 1'b0;
    tx_idle_pct = 33;
    rx_idle_pct = 51;
    cur_height  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed triangles at height zero, default tolerance.
    set_config('0, TolReset);
    send_tri(0, 0, -Q_ONE, 2 * Q_ONE, 0, Q_ONE, 0, 2 * Q_ONE, Q_ONE, 1, 1'b1);
    send_tri(0, 0, Q_ONE, Q_ONE, 0, 2 * Q_ONE, 0, Q_ONE, 3 * Q_ONE, 2, 1'b0);
    // Vertex on the plane, then a crossing triangle in the void layer.
    send_tri(Q_ONE, Q_ONE, 0, 0, 0, Q_ONE, Q_ONE, 0, -Q_ONE, 3, 1'b0);
    send_tri(0, 0, -Q_ONE, 2 * Q_ONE, 0, Q_ONE, 0, 2 * Q_ONE, Q_ONE, 4, 1'b0);
    send_tri(0, 0, -Q_ONE, 2 * Q_ONE, 0, Q_ONE, 0, 2 * Q_ONE, Q_ONE, 5, 1'b1);
    // Tip one step above the plane: both crossings fall within tolerance and cancel.
    send_tri(5, 7, 1, Q_ONE, 0, -Q_ONE, 0, Q_ONE, -Q_ONE, 6, 1'b0);
    // Full-range coordinates.
    send_tri(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
             0, 0, COORD_MAX, 7, 1'b0);
    send_tri(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
             COORD_MAX, COORD_MAX, -1, idx_t'(20'hFFFFF), 1'b1);
    send_tri(-3 * Q_ONE, -Q_ONE, Q_ONE, Q_ONE, -5 * Q_ONE, -2 * Q_ONE,
             2 * Q_ONE, 3 * Q_ONE, -Q_ONE, 9, 1'b0);
    // Vertical edge with no change in X or Y.
    send_tri(Q_ONE, Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 2 * Q_ONE, Q_ONE, 10, 1'b0);
    // Vertex on the plane on a layer start, again in the void layer, then a new layer.
    send_tri(0, 0, 0, Q_ONE, 0, Q_ONE, 0, Q_ONE, -Q_ONE, 0, 1'b1);
    send_tri(0, 0, 0, Q_ONE, 0, Q_ONE, 0, Q_ONE, -Q_ONE, 12, 1'b0);
    send_tri(0, 0, -Q_ONE, Q_ONE, 0, -Q_ONE, 0, Q_ONE, -3, 13, 1'b1);
    settle();
    // Zero tolerance: the same tip triangle now gives both crossings.
    set_config('0, '0);
    send_tri(5, 7, 1, Q_ONE, 0, -Q_ONE, 0, Q_ONE, -Q_ONE, 14, 1'b0);
    settle();

    // Random triangles around a random plane.
    set_config(coord_t'($urandom) >>> 6, TolReset);
    send_many(260);
    settle();

    // Plane at the top and bottom of the range; roles of the two sides swapped.
    set_idle(51, 33);
    set_config(COORD_MAX, '0);
    send_many(80);
    settle();
    set_config(COORD_MIN, TOL_MAX);
    send_many(80);
    settle();

    // Long receiver hold-off while triangles keep coming, then a pause until empty.
    set_config(coord_t'($urandom) >>> 8, tol_t'($urandom_range(0, 65535)));
    hold_kick <= ~hold_kick;
    send_many(130);
    wait_results();
    send_many(130);
    settle();

    // Neither side idles.
    set_idle(0, 0);
    set_config(coord_t'($urandom) >>> 4, TolReset);
    send_many(300);
    settle();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
